// File: hw/rtl/vrp_pkg.sv
// Shared types and constants of the vertex rotate and project pipeline.
`default_nettype none

package vrp_pkg;

    // Screen size defaults
    localparam int SCREEN_W_DEF = 640;
    localparam int SCREEN_H_DEF = 480;

    // Configuration register indexes
    localparam logic [2:0] REG_COS_YAW       = 3'd0;
    localparam logic [2:0] REG_SIN_YAW       = 3'd1;
    localparam logic [2:0] REG_COS_ROLL      = 3'd2;
    localparam logic [2:0] REG_SIN_ROLL      = 3'd3;
    localparam logic [2:0] REG_COS_PITCH     = 3'd4;
    localparam logic [2:0] REG_SIN_PITCH     = 3'd5;
    localparam logic [2:0] REG_VIEW_DISTANCE = 3'd6;

    // Register reset values
    localparam logic signed [15:0] COS_YAW_RST   = 16'sd16384;
    localparam logic signed [15:0] SIN_YAW_RST   = 16'sd0;
    localparam logic signed [15:0] COS_ROLL_RST  = 16'sd16384;
    localparam logic signed [15:0] SIN_ROLL_RST  = 16'sd0;
    localparam logic signed [15:0] COS_PITCH_RST = -16'sd16384;
    localparam logic signed [15:0] SIN_PITCH_RST = 16'sd26;
    localparam logic [23:0]        VIEW_DIST_RST = 24'd33280;

    typedef struct packed {
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic signed [23:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_viewer;
    } t_screen;

endpackage

`default_nettype wire

// File: hw/rtl/vertex_rotate_project_core.sv
// Top level: rotation, perspective divide and screen mapping of one vertex per cycle.
//
// Vertices enter on the input channel (i_in_valid / o_in_ready, payload i_in)
// and leave as screen positions on the output channel (o_out_valid /
// i_out_ready, payload o_out), one result for each vertex, in order.
// Rotation sines, cosines and the view distance are written through the
// configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data);
// it is always ready. The user must make writes only while the pipeline is
// empty; the block itself does not enforce this. Throughput is one vertex
// per cycle while the receiver does not stall. Each vertex passes through 24
// register stages: three rotation stages, a depth stage, a numerator stage,
// a sign and range stage, 17 restoring divide steps (one quotient bit per
// stage, one for each of the x and y dividers) and the saturating output
// register. Each stage holds when the stage after it is full and blocked,
// so bubbles close up under a stalled receiver and input is still taken
// while a result waits. Reset (synchronous, active low) empties the
// pipeline and loads the register defaults.
`default_nettype none

module vertex_rotate_project_core
    import vrp_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_vertex     i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_screen          o_out
);

    localparam int MUL_W = $clog2(((SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H) + 1);
    localparam int NUM_W = 37 + MUL_W;
    localparam int D_W   = 35;
    localparam int Q_W   = 17;
    localparam int REM_W = (NUM_W > D_W + Q_W) ? NUM_W : D_W + Q_W;
    localparam int NS    = 7 + Q_W;

    localparam logic signed [NUM_W-1:0] K_H  = NUM_W'(SCREEN_H);
    localparam logic signed [NUM_W-1:0] K_WH = NUM_W'(SCREEN_W / 2);
    localparam logic signed [NUM_W-1:0] K_HH = NUM_W'(SCREEN_H / 2);

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = -16'sh8000;

    // Configuration registers
    logic signed [15:0] r_cos_yaw, r_sin_yaw, r_cos_roll, r_sin_roll;
    logic signed [15:0] r_cos_pitch, r_sin_pitch;
    logic [23:0]        r_view_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_yaw   <= COS_YAW_RST;
            r_sin_yaw   <= SIN_YAW_RST;
            r_cos_roll  <= COS_ROLL_RST;
            r_sin_roll  <= SIN_ROLL_RST;
            r_cos_pitch <= COS_PITCH_RST;
            r_sin_pitch <= SIN_PITCH_RST;
            r_view_dist <= VIEW_DIST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COS_YAW:       r_cos_yaw   <= $signed(i_cfg_data[15:0]);
                REG_SIN_YAW:       r_sin_yaw   <= $signed(i_cfg_data[15:0]);
                REG_COS_ROLL:      r_cos_roll  <= $signed(i_cfg_data[15:0]);
                REG_SIN_ROLL:      r_sin_roll  <= $signed(i_cfg_data[15:0]);
                REG_COS_PITCH:     r_cos_pitch <= $signed(i_cfg_data[15:0]);
                REG_SIN_PITCH:     r_sin_pitch <= $signed(i_cfg_data[15:0]);
                REG_VIEW_DISTANCE: r_view_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits and per-stage advance: a stage loads when empty or draining
    logic [NS-1:0] r_v, n_v, w_adv;

    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
        n_v = r_v;
        for (int k = 0; k < NS; k++) begin
            if (w_adv[k]) begin
                n_v[k] = (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_v[NS-1];

    // Stage 0: rotate about Y
    logic signed [40:0] w_s0_x, w_s0_z;
    logic signed [26:0] r0_x1, r0_z1;
    logic signed [23:0] r0_y;

    assign w_s0_x = 41'(r_cos_yaw) * 41'($signed(i_in.vertex_x))
                  + 41'(r_sin_yaw) * 41'($signed(i_in.vertex_z)) + 41'sd8192;
    assign w_s0_z = 41'(r_cos_yaw) * 41'($signed(i_in.vertex_z))
                  - 41'(r_sin_yaw) * 41'($signed(i_in.vertex_x)) + 41'sd8192;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_x1 <= 27'(w_s0_x >>> 14);
            r0_z1 <= 27'(w_s0_z >>> 14);
            r0_y  <= $signed(i_in.vertex_y);
        end
    end

    // Stage 1: rotate about Z
    logic signed [43:0] w_s1_x, w_s1_y;
    logic signed [29:0] r1_x2, r1_y2;
    logic signed [26:0] r1_z1;

    assign w_s1_x = 44'(r_cos_roll) * 44'(r0_x1) - 44'(r_sin_roll) * 44'(r0_y)
                  + 44'sd8192;
    assign w_s1_y = 44'(r_sin_roll) * 44'(r0_x1) + 44'(r_cos_roll) * 44'(r0_y)
                  + 44'sd8192;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_x2 <= 30'(w_s1_x >>> 14);
            r1_y2 <= 30'(w_s1_y >>> 14);
            r1_z1 <= r0_z1;
        end
    end

    // Stage 2: rotate about X
    logic signed [46:0] w_s2_y, w_s2_z;
    logic signed [29:0] r2_x2;
    logic signed [32:0] r2_y3, r2_z3;

    assign w_s2_y = 47'(r_cos_pitch) * 47'(r1_y2) - 47'(r_sin_pitch) * 47'(r1_z1)
                  + 47'sd8192;
    assign w_s2_z = 47'(r_sin_pitch) * 47'(r1_y2) + 47'(r_cos_pitch) * 47'(r1_z1)
                  + 47'sd8192;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_x2 <= r1_x2;
            r2_y3 <= 33'(w_s2_y >>> 14);
            r2_z3 <= 33'(w_s2_z >>> 14);
        end
    end

    // Stage 3: depth denominator
    logic signed [29:0] r3_x2;
    logic signed [32:0] r3_y3;
    logic signed [33:0] r3_den;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_x2  <= r2_x2;
            r3_y3  <= r2_y3;
            r3_den <= $signed({10'd0, r_view_dist}) - 34'(r2_z3);
        end
    end

    // Stage 4: numerators with the screen centre folded in
    logic [D_W-1:0]            w_d2;
    logic signed [NUM_W-1:0]   r4_nx, r4_ny;
    logic [D_W-1:0]            r4_d2;
    logic                      r4_behind;

    assign w_d2 = {r3_den[D_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_nx     <= NUM_W'(r3_x2) * K_H + $signed(NUM_W'(w_d2)) * K_WH;
            r4_ny     <= NUM_W'(r3_y3) * K_H + $signed(NUM_W'(w_d2)) * K_HH;
            r4_d2     <= w_d2;
            r4_behind <= r3_den[33] || (r3_den == '0);
        end
    end

    // Divider pipeline: index 0 is the sign and range stage, then one bit per stage
    logic [REM_W-1:0] r_rx [0:Q_W];
    logic [REM_W-1:0] r_ry [0:Q_W];
    logic [Q_W-1:0]   r_qx [0:Q_W];
    logic [Q_W-1:0]   r_qy [0:Q_W];
    logic [D_W-1:0]   r_d2 [0:Q_W];
    logic             r_negx [0:Q_W];
    logic             r_negy [0:Q_W];
    logic             r_ovfx [0:Q_W];
    logic             r_ovfy [0:Q_W];
    logic             r_bhd  [0:Q_W];

    logic [NUM_W-1:0] w_ax, w_ay;
    logic [REM_W-1:0] w_dlim;

    assign w_ax   = r4_nx[NUM_W-1] ? NUM_W'(-r4_nx) : NUM_W'(r4_nx);
    assign w_ay   = r4_ny[NUM_W-1] ? NUM_W'(-r4_ny) : NUM_W'(r4_ny);
    assign w_dlim = REM_W'(r4_d2) << Q_W;

    // Stage 5: magnitudes, signs and quotient overflow
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_rx[0]   <= REM_W'(w_ax);
            r_ry[0]   <= REM_W'(w_ay);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_d2[0]   <= r4_d2;
            r_negx[0] <= r4_nx[NUM_W-1];
            r_negy[0] <= r4_ny[NUM_W-1];
            r_ovfx[0] <= REM_W'(w_ax) >= w_dlim;
            r_ovfy[0] <= REM_W'(w_ay) >= w_dlim;
            r_bhd[0]  <= r4_behind;
        end
    end

    // Restoring divide steps, most significant quotient bit first
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [REM_W-1:0] w_dsh;
        logic             w_gx, w_gy;

        assign w_dsh = REM_W'(r_d2[j]) << (Q_W - 1 - j);
        assign w_gx  = r_rx[j] >= w_dsh;
        assign w_gy  = r_ry[j] >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (w_adv[6+j]) begin
                r_rx[j+1]   <= w_gx ? r_rx[j] - w_dsh : r_rx[j];
                r_ry[j+1]   <= w_gy ? r_ry[j] - w_dsh : r_ry[j];
                r_qx[j+1]   <= r_qx[j] | (Q_W'(w_gx) << (Q_W - 1 - j));
                r_qy[j+1]   <= r_qy[j] | (Q_W'(w_gy) << (Q_W - 1 - j));
                r_d2[j+1]   <= r_d2[j];
                r_negx[j+1] <= r_negx[j];
                r_negy[j+1] <= r_negy[j];
                r_ovfx[j+1] <= r_ovfx[j];
                r_ovfy[j+1] <= r_ovfy[j];
                r_bhd[j+1]  <= r_bhd[j];
            end
        end
    end

    // Apply sign and clamp to 16 bits
    function automatic logic signed [15:0] f_sat(input logic [Q_W-1:0] q,
                                                 input logic neg, input logic ovf);
        logic signed [15:0] res;
        if (neg) begin
            res = (ovf || q > Q_W'(32768)) ? SAT_MIN : 16'(-$signed({1'b0, q}));
        end else begin
            res = (ovf || q > Q_W'(32767)) ? SAT_MAX : $signed(q[15:0]);
        end
        return res;
    endfunction

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_adv[NS-1]) begin
            if (r_bhd[Q_W]) begin
                o_out.screen_x <= '0;
                o_out.screen_y <= '0;
            end else begin
                o_out.screen_x <= f_sat(r_qx[Q_W], r_negx[Q_W], r_ovfx[Q_W]);
                o_out.screen_y <= f_sat(r_qy[Q_W], r_negy[Q_W], r_ovfy[Q_W]);
            end
            o_out.behind_viewer <= r_bhd[Q_W];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vrp_checker.sv
// Port-level checker for the vertex rotate and project core, with its bind.
`default_nettype none

module vrp_checker
    import vrp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_screen     o_out
);

    // Hold a stalled result until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // Clear the pipeline on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An empty output register never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with output free");

    // Vertices behind the viewer map to the origin
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.behind_viewer |->
            o_out.screen_x == 16'sd0 && o_out.screen_y == 16'sd0)
        else $error("behind-viewer result has non-zero position");

endmodule

bind vertex_rotate_project_core vrp_checker u_vrp_checker (.*);

`default_nettype wire
